FILE: hdl/scfw_pkg.sv
// Package for the servo channel failsafe watchdog: channel count, request and
// LED codes, register indexes, reset values and the job record.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package scfw_pkg;

   localparam int CHANNELS    = 6;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] REQ_SET_CHANNEL  = 2'd0;
   localparam logic [1:0] REQ_SET_FAILSAFE = 2'd1;
   localparam logic [1:0] REQ_QUERY        = 2'd2;
   localparam logic [1:0] REQ_TICK         = 2'd3;

   localparam logic [1:0] LED_WAITING  = 2'd0;
   localparam logic [1:0] LED_ACTIVE   = 2'd1;
   localparam logic [1:0] LED_FAILSAFE = 2'd2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] REFRESH_RESET = 16'd20;
   localparam logic [15:0] STARTUP_RESET = 16'd2000;

   localparam logic       KIND_DRIVE    = 1'b0;
   localparam logic       KIND_RESPONSE = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic [7:0]                   channel;
      logic [15:0]                  pulse;
      logic                         status;
      logic                         drive_enabled;
      logic                         failsafe_engaged;
      logic [1:0]                   led_mode;
      logic [CHANNELS-1:0]          mask;
      logic [CHANNELS-1:0][15:0]    values;
   } job_type;

endpackage

FILE: hdl/servo_channel_failsafe_watchdog_core.sv
// Top level of the servo channel failsafe watchdog: front part, job queue
// and back part. Depends on scfw_pkg, scfw_front, scfw_queue and scfw_back.
//
//   Channel  Direction  Beat contents
//   req_     in         tuser: request type; tdata: channel, pulse
//   rsp_     out        tuser: kind; tlast: last; tdata: channel, pulse, status,
//                       drive enabled, failsafe engaged, LED mode
//   csr_     in         register index and 16-bit value, no read-back
//
// A request beat is taken in the cycle it arrives while the two-entry job
// queue has room. The back part plays out one result beat per cycle while
// rsp_tready allows, so a tick that drives the channels yields up to six
// beats, once the job has been loaded from the queue. Reset clears stores,
// counters and flags. A stalled result channel fills the queue, then holds
// req_tready low.
`timescale 1ns / 1ps
module servo_channel_failsafe_watchdog_core
   import scfw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // channel[7:0], pulse[23:8]
   input  logic [1:0]            req_tuser,  // request type[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_channel[7:0], out_pulse[23:8], status[24], drive_enabled[25],
   // failsafe_engaged[26], led_mode[28:27], zero[31:29]
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tuser,  // kind[0]
   output logic                  rsp_tlast
);

   logic    q_ready, push, pop, head_valid;
   job_type job, head_job;

   assign req_tready = q_ready;

   scfw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_type    (req_tuser),
      .req_channel (req_tdata[7:0]),
      .req_pulse   (req_tdata[23:8]),
      .q_ready     (q_ready),
      .push        (push),
      .job         (job)
   );

   scfw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (job),
      .ready      (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   scfw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hdl/scfw_front.sv
// Front part: takes request and tick beats, updates the channel stores,
// counters and mode flags, and hands each result-producing item on as a job.
// Depends on scfw_pkg.
`timescale 1ns / 1ps
module scfw_front
   import scfw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  req_tvalid,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_channel,
   input  logic [15:0]           req_pulse,
   input  logic                  q_ready,
   output logic                  push,
   output job_type               job
);

   logic [15:0] tmo_ff, rfr_ff, stu_ff;
   logic [CHANNELS-1:0][15:0] chan_ff, chan_in;
   logic [CHANNELS-1:0][15:0] fsv_ff, fsv_in;
   logic [15:0] wd_ff, wd_in, rc_ff, rc_in, sc_ff, sc_in;
   logic        en_ff, en_in, fs_ff, fs_in;
   logic [1:0]  led_ff, led_in;

   logic        accept, ok, fired, start_hit, rfr_hit, due;
   logic [15:0] wd_inc, rc_inc, sc_inc, fs_read;
   logic [CHANNELS-1:0] fs_mask;

   assign accept = req_tvalid && q_ready;

   always_comb begin
      ok      = req_channel < 8'(CHANNELS);
      fs_read = 16'd0;
      chan_in = chan_ff;
      fsv_in  = fsv_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         fs_mask[i] = ~fsv_ff[i][15];
         if (req_channel == 8'(i)) begin
            fs_read = fsv_ff[i];
            if (req_type == REQ_SET_CHANNEL) chan_in[i] = req_pulse;
            if (req_type == REQ_SET_FAILSAFE) fsv_in[i] = req_pulse;
         end
      end

      wd_inc    = (wd_ff == 16'hFFFF) ? wd_ff : wd_ff + 16'd1;
      rc_inc    = (rc_ff == 16'hFFFF) ? rc_ff : rc_ff + 16'd1;
      sc_inc    = (sc_ff == 16'hFFFF) ? sc_ff : sc_ff + 16'd1;
      fired     = wd_inc >= tmo_ff;
      start_hit = !en_ff && (sc_inc >= stu_ff);
      rfr_hit   = en_ff && (rc_inc >= rfr_ff);
      due       = start_hit || rfr_hit;

      wd_in  = wd_ff;
      rc_in  = rc_ff;
      sc_in  = sc_ff;
      en_in  = en_ff;
      fs_in  = fs_ff;
      led_in = led_ff;
      push   = 1'b0;

      job = '0;
      job.status = !ok;

      case (req_type)
         REQ_SET_CHANNEL: begin
            if (ok) begin
               wd_in = 16'd0;
               fs_in = 1'b0;
               if (fs_ff) led_in = LED_ACTIVE;
            end
            push = accept;
         end
         REQ_SET_FAILSAFE: begin
            push = accept;
         end
         REQ_QUERY: begin
            push = accept;
         end
         default: begin
            wd_in = fired ? 16'd0 : wd_inc;
            if (fired) begin
               fs_in = 1'b1;
               if (!fs_ff) led_in = LED_FAILSAFE;
            end
            if (!en_ff) begin
               sc_in = sc_inc;
               if (start_hit) begin
                  en_in = 1'b1;
                  rc_in = 16'd0;
               end
            end else begin
               rc_in = rfr_hit ? 16'd0 : rc_inc;
            end
            push = accept && ((fired && (fs_mask != '0)) || (!fired && due && !fs_ff));
         end
      endcase

      job.drive_enabled    = en_in;
      job.failsafe_engaged = fs_in;
      job.led_mode         = led_in;
      if (req_type == REQ_TICK) begin
         job.kind   = KIND_DRIVE;
         job.status = 1'b0;
         job.mask   = fired ? fs_mask : '1;
         job.values = fired ? fsv_ff : chan_ff;
      end else begin
         job.kind    = KIND_RESPONSE;
         job.channel = req_channel;
         job.mask    = CHANNELS'(1);
         if (!ok) job.pulse = 16'hFFFF;
         else if (req_type == REQ_QUERY) job.pulse = fs_read;
         else job.pulse = req_pulse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff  <= TIMEOUT_RESET;
         rfr_ff  <= REFRESH_RESET;
         stu_ff  <= STARTUP_RESET;
         chan_ff <= '0;
         fsv_ff  <= '0;
         wd_ff   <= 16'd0;
         rc_ff   <= 16'd0;
         sc_ff   <= 16'd0;
         en_ff   <= 1'b0;
         fs_ff   <= 1'b0;
         led_ff  <= LED_WAITING;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: tmo_ff <= csr_wdata;
               CSR_REFRESH: rfr_ff <= csr_wdata;
               CSR_STARTUP: stu_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            if (ok) begin
               chan_ff <= chan_in;
               fsv_ff  <= fsv_in;
            end
            wd_ff  <= wd_in;
            rc_ff  <= rc_in;
            sc_ff  <= sc_in;
            en_ff  <= en_in;
            fs_ff  <= fs_in;
            led_ff <= led_in;
         end
      end
   end

endmodule

FILE: hdl/scfw_queue.sv
// Short job queue between the front and back parts.
// Depends on scfw_pkg.
`timescale 1ns / 1ps
module scfw_queue
   import scfw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   output logic     ready,
   input  logic     pop,
   output logic     head_valid,
   output job_type  head_job
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign ready      = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + QCNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_job;
   end

endmodule

FILE: hdl/scfw_back.sv
// Back part: takes jobs from the queue and plays them out as result beats,
// one channel per cycle when not stalled, into the output register.
// Depends on scfw_pkg.
`timescale 1ns / 1ps
module scfw_back
   import scfw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  job_type       head_job,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   job_type             cur_ff, cur_in;
   logic                busy_ff, busy_in;
   logic [CHANNELS-1:0] mask_ff, mask_in, rest;
   logic [CH_IDX_W-1:0] sel;
   logic                out_free, emit, done;

   logic        vld_ff, vld_in;
   logic [31:0] data_ff, data_in;
   logic        user_ff, user_in, lst_ff, lst_in;
   logic [7:0]  o_chan;
   logic [15:0] o_pulse;

   assign out_free = !vld_ff || rsp_tready;

   always_comb begin
      sel = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel = CH_IDX_W'(i);
      end
      rest = mask_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         if (sel == CH_IDX_W'(i)) rest[i] = 1'b0;
      end

      emit = busy_ff && out_free;
      done = emit && (rest == '0);
      pop  = head_valid && (!busy_ff || done);

      cur_in  = pop ? head_job : cur_ff;
      busy_in = pop ? 1'b1 : (done ? 1'b0 : busy_ff);
      mask_in = pop ? head_job.mask : (emit ? rest : mask_ff);

      o_chan  = (cur_ff.kind == KIND_RESPONSE) ? cur_ff.channel : 8'(sel);
      o_pulse = (cur_ff.kind == KIND_RESPONSE) ? cur_ff.pulse : cur_ff.values[sel];
      data_in = {3'b000, cur_ff.led_mode, cur_ff.failsafe_engaged, cur_ff.drive_enabled,
                 cur_ff.status, o_pulse, o_chan};
      user_in = cur_ff.kind;
      lst_in  = rest == '0;
      vld_in  = emit ? 1'b1 : (rsp_tready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      mask_ff <= mask_in;
      if (emit) begin
         data_ff <= data_in;
         user_ff <= user_in;
         lst_ff  <= lst_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = lst_ff;

endmodule

FILE: dv/scfw_checker.sv
// Result checker for the servo channel failsafe watchdog: follows register writes and
// request beats, predicts every result beat and compares the result channel against it.
// Depends on scfw_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps
module scfw_checker
   import scfw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,  // channel[7:0], pulse[23:8]
   input  logic [1:0]            req_tuser,  // request type[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_channel[7:0], out_pulse[23:8], status[24], drive_enabled[25],
   // failsafe_engaged[26], led_mode[28:27], zero[31:29]
   input  logic [31:0]           rsp_tdata,
   input  logic                  rsp_tuser,  // kind[0]
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    pending_beats,
   output int                    beats_checked
);

   localparam int PRINT_CAP = 100;

   typedef struct {
      logic        kind;
      logic [7:0]  chan;
      logic [15:0] pulse;
      logic        status;
      logic        drive_en;
      logic        fs_on;
      logic [1:0]  led;
      logic        last;
   } servo_beat_type;

   servo_beat_type expected_beats[$];

   logic [15:0] timeout_cfg;
   logic [15:0] refresh_cfg;
   logic [15:0] startup_cfg;
   logic [15:0] pulse_store [CHANNELS];
   logic [15:0] failsafe_store [CHANNELS];
   logic [15:0] link_count;
   logic [15:0] refresh_count;
   logic [15:0] startup_count;
   logic        drive_on;
   logic        failsafe_on;
   logic [1:0]  led_state;
   int          errors = 0;
   int          checked = 0;

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_CAP) begin
         $display("scfw_checker: %s", msg);
      end
   endtask

   task automatic clear_model();
      timeout_cfg   = TIMEOUT_RESET;
      refresh_cfg   = REFRESH_RESET;
      startup_cfg   = STARTUP_RESET;
      link_count    = '0;
      refresh_count = '0;
      startup_count = '0;
      drive_on      = 1'b0;
      failsafe_on   = 1'b0;
      led_state     = LED_WAITING;
      for (int c = 0; c < CHANNELS; c++) begin
         pulse_store[c]    = '0;
         failsafe_store[c] = '0;
      end
      expected_beats.delete();
   endtask

   function automatic servo_beat_type make_beat(logic kind, logic [7:0] chan,
                                                logic [15:0] pulse, logic status);
      servo_beat_type b;
      b.kind     = kind;
      b.chan     = chan;
      b.pulse    = pulse;
      b.status   = status;
      b.drive_en = 1'b0;
      b.fs_on    = 1'b0;
      b.led      = LED_WAITING;
      b.last     = 1'b0;
      return b;
   endfunction

   task automatic predict_request(logic [1:0] op, logic [7:0] chan, logic [15:0] pulse);
      servo_beat_type staged[$];
      bit             ok;
      bit             fired;
      bit             due;
      ok    = chan < CHANNELS;
      fired = 1'b0;
      due   = 1'b0;
      case (op)
         REQ_SET_CHANNEL: begin
            if (ok) begin
               pulse_store[chan] = pulse;
               link_count = '0;
               if (failsafe_on) led_state = LED_ACTIVE;
               failsafe_on = 1'b0;
            end
            staged.push_back(make_beat(KIND_RESPONSE, chan, ok ? pulse : 16'hFFFF, !ok));
         end
         REQ_SET_FAILSAFE: begin
            if (ok) failsafe_store[chan] = pulse;
            staged.push_back(make_beat(KIND_RESPONSE, chan, ok ? pulse : 16'hFFFF, !ok));
         end
         REQ_QUERY: begin
            staged.push_back(make_beat(KIND_RESPONSE, chan,
                                       ok ? failsafe_store[chan] : 16'hFFFF, !ok));
         end
         default: begin
            if (link_count != 16'hFFFF) link_count++;
            if (link_count >= timeout_cfg) begin
               link_count = '0;
               fired = 1'b1;
               if (!failsafe_on) led_state = LED_FAILSAFE;
               failsafe_on = 1'b1;
            end
            if (!drive_on) begin
               if (startup_count != 16'hFFFF) startup_count++;
               if (startup_count >= startup_cfg) begin
                  drive_on = 1'b1;
                  refresh_count = '0;
                  due = 1'b1;
               end
            end else begin
               if (refresh_count != 16'hFFFF) refresh_count++;
               if (refresh_count >= refresh_cfg) begin
                  refresh_count = '0;
                  due = 1'b1;
               end
            end
            if (fired) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (!failsafe_store[c][15]) begin
                     staged.push_back(make_beat(KIND_DRIVE, 8'(c), failsafe_store[c], 1'b0));
                  end
               end
            end else if (due && !failsafe_on) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  staged.push_back(make_beat(KIND_DRIVE, 8'(c), pulse_store[c], 1'b0));
               end
            end
         end
      endcase
      foreach (staged[i]) begin
         staged[i].drive_en = drive_on;
         staged[i].fs_on    = failsafe_on;
         staged[i].led      = led_state;
         staged[i].last     = (i == staged.size() - 1);
         expected_beats.push_back(staged[i]);
      end
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result beat %0d: %s is %h, expected %h",
                                   checked, name, got, want));
      end
   endtask

   task automatic check_result();
      servo_beat_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing expected: tdata %h tuser %b tlast %b",
                                   rsp_tdata, rsp_tuser, rsp_tlast));
         return;
      end
      want = expected_beats.pop_front();
      checked++;
      compare_field("kind", 16'(rsp_tuser), 16'(want.kind));
      compare_field("channel", 16'(rsp_tdata[7:0]), 16'(want.chan));
      compare_field("pulse", rsp_tdata[23:8], want.pulse);
      compare_field("status", 16'(rsp_tdata[24]), 16'(want.status));
      compare_field("drive_enabled", 16'(rsp_tdata[25]), 16'(want.drive_en));
      compare_field("failsafe_engaged", 16'(rsp_tdata[26]), 16'(want.fs_on));
      compare_field("led_mode", 16'(rsp_tdata[28:27]), 16'(want.led));
      compare_field("padding", 16'(rsp_tdata[31:29]), 16'd0);
      compare_field("last", 16'(rsp_tlast), 16'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_cfg = csr_wdata;
               CSR_REFRESH: refresh_cfg = csr_wdata;
               CSR_STARTUP: startup_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata[7:0], req_tdata[23:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
      fail_count    <= errors;
      pending_beats <= expected_beats.size();
      beats_checked <= checked;
   end

endmodule

FILE: dv/tb_top.sv
// Top of the servo channel failsafe watchdog testbench: clock, reset, register writes,
// request stimulus with random gaps, a randomly stalling result sink and the verdict.
// Depends on scfw_pkg, servo_channel_failsafe_watchdog_core and scfw_checker.
`timescale 1ns / 1ps
module tb_top;
   import scfw_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int RESET_CYCLES  = 6;
   localparam int TAIL_CYCLES   = 16;
   localparam int PRESSURE_AT   = 120;
   localparam int PRESSURE_HOLD = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;   // channel[7:0], pulse[23:8]
   logic [1:0]           req_tuser;   // request type[1:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // out_channel[7:0], out_pulse[23:8], status[24], drive_enabled[25],
   // failsafe_engaged[26], led_mode[28:27], zero[31:29]
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;   // kind[0]
   logic                 rsp_tlast;

   int fail_count;
   int pending_beats;
   int beats_checked;
   int items_sent = 0;
   int config_count = 0;
   bit steady_phase = 1'b0;
   bit pressure_done = 1'b0;

   servo_channel_failsafe_watchdog_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   scfw_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .beats_checked (beats_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 90);
   endfunction

   task automatic send_item(logic [1:0] op, logic [7:0] chan, logic [15:0] value);
      int gap;
      gap = steady_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, chan};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_config(logic [15:0] timeout, logic [15:0] refresh, logic [15:0] startup);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= CSR_REFRESH;
      csr_wdata <= refresh;
      @(posedge clock);
      csr_index <= CSR_STARTUP;
      csr_wdata <= startup;
      @(posedge clock);
      csr_we <= 1'b0;
      config_count++;
   endtask

   // The block may still be working through a tick that yields no beat once the
   // last expected beat has gone, hence the tail before anything else is written.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic random_item(int set_pct);
      int          r;
      logic [1:0]  op;
      logic [7:0]  chan;
      logic [15:0] value;
      r = $urandom_range(0, 99);
      if (r < set_pct) op = REQ_SET_CHANNEL;
      else if (r < set_pct + 15) op = REQ_SET_FAILSAFE;
      else if (r < set_pct + 27) op = REQ_QUERY;
      else op = REQ_TICK;
      if ($urandom_range(0, 99) < 88) chan = 8'($urandom_range(0, CHANNELS - 1));
      else chan = 8'($urandom_range(CHANNELS, 255));
      r = $urandom_range(0, 99);
      if (r < 80) value = 16'($urandom);
      else begin
         case (r % 4)
            0: value = 16'h7FFF;
            1: value = 16'h8000;
            2: value = 16'h0000;
            default: value = 16'hFFFF;
         endcase
      end
      send_item(op, chan, value);
   endtask

   task automatic run_phase(int count, logic [15:0] timeout, logic [15:0] refresh,
                            logic [15:0] startup);
      int set_pct;
      write_config(timeout, refresh, startup);
      set_pct = $urandom_range(5, 35);
      steady_phase = ($urandom_range(0, 3) == 0);
      repeat (count) random_item(set_pct);
      steady_phase = 1'b0;
      settle();
   endtask

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int gap;
      int run;
      int held;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < PRESSURE_HOLD; held++) @(posedge clock);
            pressure_done = 1'b1;
         end else begin
            run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(60, 200);
            gap = pick_gap();
            rsp_tready <= 1'b1;
            repeat (run) @(posedge clock);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_TIMEOUT;
      csr_wdata  <= 16'h0000;
      req_tvalid <= 1'b0;
      req_tuser  <= REQ_TICK;
      req_tdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: stores, bad indexes, a holding failsafe value and queries.
      send_item(REQ_SET_CHANNEL, 8'd0, 16'h7FFF);
      send_item(REQ_SET_CHANNEL, 8'd5, 16'h8000);
      send_item(REQ_SET_CHANNEL, 8'd6, 16'h1234);
      send_item(REQ_SET_CHANNEL, 8'd255, 16'hFFFF);
      send_item(REQ_SET_FAILSAFE, 8'd1, 16'hFFFF);
      send_item(REQ_SET_FAILSAFE, 8'd2, 16'h7FFF);
      send_item(REQ_SET_FAILSAFE, 8'd128, 16'h5555);
      send_item(REQ_QUERY, 8'd2, 16'h0000);
      send_item(REQ_QUERY, 8'd1, 16'hAAAA);
      send_item(REQ_QUERY, 8'd6, 16'h0000);
      send_item(REQ_TICK, 8'd0, 16'h0000);
      send_item(REQ_TICK, 8'd0, 16'h0000);
      settle();

      // Failsafe fires twice while the drive is still disabled, then the drive is
      // enabled; a channel write leaves failsafe and the next tick refreshes.
      csr_we    <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'hFFFF;
      @(posedge clock);
      write_config(16'd2, 16'd1, 16'd6);
      repeat (4) send_item(REQ_TICK, 8'hFF, 16'hFFFF);
      send_item(REQ_SET_CHANNEL, 8'd3, 16'h0AAA);
      send_item(REQ_TICK, 8'd0, 16'h0000);
      settle();

      // Zero periods: both the watchdog and the refresh fire on every tick.
      write_config(16'd0, 16'd0, 16'd0);
      send_item(REQ_TICK, 8'd0, 16'h0000);
      send_item(REQ_SET_CHANNEL, 8'd2, 16'h0001);
      send_item(REQ_TICK, 8'd0, 16'h0000);
      send_item(REQ_TICK, 8'd0, 16'h0000);
      settle();

      run_phase(56, 16'd5, 16'd3, 16'd0);
      run_phase(56, 16'd12, 16'd1, 16'd30);
      run_phase(56, 16'd1, 16'd7, 16'hFFFF);
      run_phase(56, 16'd40, 16'd10, 16'd5);
      run_phase(56, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(56, 16'd3, 16'd2, 16'd1);
      run_phase(56, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 8)),
                16'($urandom_range(0, 20)));
      run_phase(56, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 8)),
                16'($urandom_range(0, 20)));

      $display("tb_top: %0d request beats under %0d register settings, %0d result beats checked",
               items_sent, config_count, beats_checked);
      $display("tb_top: long result hold-off of %0d cycles applied: %0d", PRESSURE_HOLD,
               pressure_done);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
